// File: src/leb_pkg.sv
package leb_pkg;

    localparam int unsigned MaxBytesShort = 5;
    localparam int unsigned MaxBytesLong  = 10;

    typedef enum logic [2:0] {
        MODE_U32 = 3'd0,
        MODE_U64 = 3'd1,
        MODE_S32 = 3'd2,
        MODE_S33 = 3'd3,
        MODE_S64 = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    // One classified byte as it travels from the front end to the decode stage.
    typedef struct packed {
        logic [6:0] payload;
        logic       cont;
        logic       hi_u32;      // bits 7:4 nonzero
        logic       hi_u64;      // bits 7:1 nonzero
        t_mode      mode;
        logic       region_end;
    } t_entry;

    // Sign-extension mask: ones from bit 7*(pos+1) upward, none past bit 63.
    function automatic logic [63:0] ext_mask(input logic [3:0] pos);
        logic [6:0] sh;
        sh = 7'(({3'd0, pos} + 7'd1) * 7'd7);
        if (sh >= 7'd64) begin
            return 64'd0;
        end
        return {64{1'b1}} << sh;
    endfunction

endpackage

// File: src/leb128_stream_decoder.sv
// LEB128 stream decoder.
// Input channel (i_valid / o_stall): one byte of the encoded stream per
// request, with the format code (taken from the first byte of each value)
// and a region-end flag that marks the last byte available.
// Output channel (o_valid / i_stall): one request per decoded value with the
// 64-bit value pattern, its byte length and a status (ok, overflow, too long,
// truncated). Bytes that do not finish a value give no output request.
// Throughput: one byte per cycle while the queue is not full; the shift-or
// and compare in the decode stage are combinational. A byte that finishes a
// value passes the queue and then the output register before its result shows.
// A four-entry queue sits between the byte front end and the decode stage,
// so input is still taken while a result waits; o_stall rises only once the
// queue is full, which happens only after the receiver holds i_stall.
// A stalled result holds steady on the output ports.
// Synchronous reset empties the queue, drops any value in progress and
// clears the output valid.
module leb128_stream_decoder
    import leb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [2:0]  i_mode,
    input  logic        i_region_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_decoded_value,
    output logic [3:0]  o_byte_length,
    output logic [1:0]  o_status
);

    t_entry push_entry, head_entry;
    logic   push, pop, full, nonempty;

    // Front end: take bytes and classify them.
    leb_front u_front (
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_mode       (i_mode),
        .i_region_end (i_region_end),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Decouple front end from decode so each can stall on its own.
    leb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head_entry)
    );

    // Decode stage: accumulate payload, detect errors, register the result.
    leb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (nonempty),
        .i_head          (head_entry),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_decoded_value (o_decoded_value),
        .o_byte_length   (o_byte_length),
        .o_status        (o_status)
    );

endmodule

// File: src/leb_front.sv
module leb_front
    import leb_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic [2:0] i_mode,
    input  logic       i_region_end,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_entry     o_entry
);

    t_mode mode_norm;

    // Fold unknown mode codes onto u32.
    always_comb begin
        unique case (i_mode)
            MODE_U64: mode_norm = MODE_U64;
            MODE_S32: mode_norm = MODE_S32;
            MODE_S33: mode_norm = MODE_S33;
            MODE_S64: mode_norm = MODE_S64;
            default:  mode_norm = MODE_U32;
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_entry.payload    = i_data_byte[6:0];
        o_entry.cont       = i_data_byte[7];
        o_entry.hi_u32     = |i_data_byte[7:4];
        o_entry.hi_u64     = |i_data_byte[7:1];
        o_entry.mode       = mode_norm;
        o_entry.region_end = i_region_end;
    end

endmodule

// File: src/leb_queue.sv
module leb_queue
    import leb_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_nonempty,
    output t_entry o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full     = (r_count == FullCnt);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: src/leb_back.sv
module leb_back
    import leb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_entry      i_head,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [63:0] o_decoded_value,
    output logic [3:0]  o_byte_length,
    output logic [1:0]  o_status
);

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_pos, n_pos;
    t_mode       r_mode, n_mode;
    logic        r_out_valid;
    logic [63:0] r_value;
    logic [3:0]  r_len;
    t_status     r_status;

    t_mode       mode;
    logic        is_signed, is_long, last, hi_bits, done, out_free;
    logic [3:0]  max_last;
    logic [63:0] acc_base, acc_new, value;
    t_status     status;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_nonempty && out_free;

    always_comb begin
        mode      = (r_pos == '0) ? i_head.mode : r_mode;
        is_long   = (mode == MODE_U64) || (mode == MODE_S64);
        is_signed = (mode == MODE_S32) || (mode == MODE_S33) || (mode == MODE_S64);
        max_last  = is_long ? 4'(MaxBytesLong - 1) : 4'(MaxBytesShort - 1);
        last      = (r_pos == max_last);
        hi_bits   = (mode == MODE_U32) ? i_head.hi_u32 : i_head.hi_u64;
        acc_base  = (r_pos == '0) ? 64'd0 : r_acc;
        acc_new   = acc_base | ({57'd0, i_head.payload} << (7 * r_pos));
        value     = 64'd0;
        status    = ST_OK;
        done      = 1'b0;
        if (!is_signed && last && hi_bits) begin
            status = ST_OVERFLOW;
            done   = 1'b1;
        end else if (!i_head.cont) begin
            value = acc_new;
            if (is_signed && i_head.payload[6]) begin
                value = acc_new | ext_mask(r_pos);
            end
            done = 1'b1;
        end else if (last) begin
            status = ST_TOO_LONG;
            done   = 1'b1;
        end else if (i_head.region_end) begin
            status = ST_TRUNCATED;
            done   = 1'b1;
        end
    end

    // Advance the value in progress; restart after each result.
    always_comb begin
        n_acc  = r_acc;
        n_pos  = r_pos;
        n_mode = r_mode;
        if (o_pop) begin
            if (done) begin
                n_pos  = '0;
                n_mode = MODE_U32;
            end else begin
                n_acc  = acc_new;
                n_pos  = r_pos + 1'b1;
                n_mode = mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pos       <= '0;
            r_mode      <= MODE_U32;
            r_out_valid <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pos  <= n_pos;
            r_mode <= n_mode;
            if (out_free) begin
                r_out_valid <= o_pop && done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && done) begin
            r_value  <= value;
            r_len    <= r_pos + 1'b1;
            r_status <= status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_decoded_value = r_value;
    assign o_byte_length   = r_len;
    assign o_status        = r_status;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

// Byte-stream checker for the LEB128 decoder: a queue of stream bytes feeds a
// clocked driver, a clocked monitor takes decoded values, and a predictor
// kept in step with accepted requests supplies the expected value per result.
module tb;
    import leb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake
    localparam int unsigned DRAIN_CYCLES   = 8;     // result latency plus slack
    localparam int unsigned RANDOM_BYTES   = 700;

    // One request on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] mode;
        logic       region_end;
    } t_stream_byte;

    // One decoded value as the output channel should carry it.
    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  length;
        t_status     status;
    } t_decoded;

    // Shapes of generated byte sequences.
    typedef enum logic [1:0] {
        GEN_CLEAN,      // well-formed value, terminated in time
        GEN_TRUNCATED,  // cut off by the region-end flag
        GEN_OVERLONG    // runs into the last permitted byte badly
    } t_gen_kind;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte     = '0;
    logic [2:0]  i_mode          = '0;
    logic        i_region_end    = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [63:0] o_decoded_value;
    logic [3:0]  o_byte_length;
    logic [1:0]  o_status;

    t_stream_byte stream_bytes[$];     // requests not yet offered
    t_decoded     decoded_expect[$];   // values predicted but not yet seen

    // Predictor state: mirrors the value in progress inside the decoder.
    logic [63:0] dec_acc  = '0;
    logic [3:0]  dec_pos  = '0;
    logic [2:0]  dec_mode = '0;

    int unsigned send_gap     = 0;
    int unsigned send_burst   = 0;
    int unsigned recv_hold    = 0;
    int unsigned recv_burst   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned error_count  = 0;
    int unsigned bytes_taken  = 0;
    int unsigned values_seen  = 0;
    int unsigned status_count[4];
    int unsigned bytes_queued = 0;

    leb128_stream_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_mode          (i_mode),
        .i_region_end    (i_region_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_decoded_value (o_decoded_value),
        .o_byte_length   (o_byte_length),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Draw the wait before the next request. Occasionally start a burst in
    // which no waits are inserted at all.
    function automatic int unsigned pick_wait(inout int unsigned burst);
        if (burst != 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            burst = $urandom_range(10, 40);
        end
        return $urandom_range(0, 7);
    endfunction

    // Advance the predicted decoder by one accepted byte; queue a result when
    // the byte finishes a value, then restart as the decoder does.
    task automatic predict_byte(input logic [7:0] b, input logic [2:0] mode_in,
                                input logic re);
        logic [2:0]  fmt;
        logic        is_signed;
        logic        hi_bits;
        logic        finished;
        int unsigned last_pos;
        int unsigned shift;
        t_decoded    r;

        if (dec_pos == 0) begin
            dec_mode = mode_in;
            dec_acc  = '0;
        end
        // Unknown format codes fall back to u32.
        fmt       = (dec_mode > MODE_S64) ? MODE_U32 : dec_mode;
        is_signed = (fmt == MODE_S32) || (fmt == MODE_S33) || (fmt == MODE_S64);
        last_pos  = ((fmt == MODE_U64) || (fmt == MODE_S64)) ? MaxBytesLong - 1
                                                            : MaxBytesShort - 1;
        // High bits that do not fit on the last permitted unsigned byte; the
        // continuation bit is among them.
        hi_bits   = (fmt == MODE_U32) ? (b[7:4] != 0) : (b[7:1] != 0);
        shift     = 7 * dec_pos;

        finished = 1'b1;
        r.value  = '0;
        r.length = 4'(dec_pos + 1);
        r.status = ST_OK;
        if (!is_signed && dec_pos == last_pos && hi_bits) begin
            r.status = ST_OVERFLOW;
        end else begin
            dec_acc |= {57'd0, b[6:0]} << shift;
            if (!b[7]) begin
                if (is_signed && shift + 7 < 64 && b[6]) begin
                    dec_acc |= {64{1'b1}} << (shift + 7);
                end
                r.value = dec_acc;
            end else if (dec_pos == last_pos) begin
                // Too long wins over a region end on the same byte.
                r.status = ST_TOO_LONG;
            end else if (re) begin
                r.status = ST_TRUNCATED;
            end else begin
                finished = 1'b0;
            end
        end

        if (finished) begin
            decoded_expect = {decoded_expect, r};
            dec_pos  = '0;
            dec_mode = '0;
            dec_acc  = '0;
        end else begin
            dec_pos++;
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic [2:0] mode,
                             input logic re);
        t_stream_byte sb;
        sb.data       = data;
        sb.mode       = mode;
        sb.region_end = re;
        stream_bytes = {stream_bytes, sb};
        bytes_queued++;
    endtask

    // Queue one encoded value of the given shape. Later bytes carry a random
    // format code, which the decoder must ignore.
    task automatic emit_value(input logic [2:0] mode, input t_gen_kind kind,
                              input int unsigned len_in);
        logic [2:0]  fmt;
        logic        is_unsigned;
        logic [7:0]  b;
        logic [7:0]  hi_mask;
        logic        re;
        int unsigned max_len;
        int unsigned len;

        fmt         = (mode > MODE_S64) ? MODE_U32 : mode;
        is_unsigned = (fmt == MODE_U32) || (fmt == MODE_U64);
        max_len     = ((fmt == MODE_U64) || (fmt == MODE_S64)) ? MaxBytesLong
                                                              : MaxBytesShort;
        hi_mask     = (fmt == MODE_U32) ? 8'hf0 : 8'hfe;
        len         = (len_in > max_len) ? max_len : len_in;
        if (kind == GEN_TRUNCATED && len >= max_len) begin
            len = max_len - 1;
        end
        if (kind == GEN_OVERLONG) begin
            len = max_len;
        end

        for (int unsigned i = 0; i < len; i++) begin
            b  = 8'($urandom_range(0, 255));
            re = 1'b0;
            if (i + 1 < len) begin
                b[7] = 1'b1;
            end else begin
                case (kind)
                    GEN_CLEAN: begin
                        b[7] = 1'b0;
                        if (is_unsigned && i + 1 == max_len) begin
                            b &= ~hi_mask;
                        end
                        re = ($urandom_range(0, 7) == 0);
                    end
                    GEN_TRUNCATED: begin
                        b[7] = 1'b1;
                        re   = 1'b1;
                    end
                    default: begin
                        // Force high bits (or a continuation) onto the last byte.
                        if (!is_unsigned || (b & hi_mask) == 0) begin
                            b[7] = 1'b1;
                        end
                        re = 1'($urandom_range(0, 1));
                    end
                endcase
            end
            push_byte(b, (i == 0) ? mode : 3'($urandom_range(0, 7)), re);
        end
    endtask

    // Queue a few raw bytes, then a byte with the continuation bit clear so
    // the decoder is back at the start of a value afterwards.
    task automatic emit_noise(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            push_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                      ($urandom_range(0, 3) == 0));
        end
        push_byte({1'b0, 7'($urandom_range(0, 127))}, 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
    endtask

    function automatic logic [2:0] pick_mode();
        if ($urandom_range(0, 15) == 0) begin
            return 3'($urandom_range(5, 7));
        end
        return 3'($urandom_range(0, 4));
    endfunction

    // Put the next queued request on the input ports.
    task automatic offer_next();
        t_stream_byte sb;
        sb = stream_bytes.pop_front();
        i_data_byte  <= sb.data;
        i_mode       <= sb.mode;
        i_region_end <= sb.region_end;
        i_valid      <= 1'b1;
    endtask

    // Driver: predict each accepted request, then either offer the next one
    // at once or drop valid for a drawn number of cycles.
    always @(posedge i_clk) begin : driver
        int unsigned w;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_byte(i_data_byte, i_mode, i_region_end);
                bytes_taken++;
                w = pick_wait(send_burst);
                if (w == 0 && stream_bytes.size() != 0) begin
                    offer_next();
                end else begin
                    i_valid  <= 1'b0;
                    send_gap <= (w != 0) ? w - 1 : 0;
                end
            end else if (!i_valid) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (stream_bytes.size() != 0) begin
                    offer_next();
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction and
    // hold stall for a drawn number of cycles after it.
    always @(posedge i_clk) begin : monitor
        t_decoded    want;
        int unsigned w;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                values_seen++;
                status_count[o_status]++;
                if (decoded_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h len=%0d st=%0d",
                                              o_decoded_value, o_byte_length, o_status));
                end else begin
                    want = decoded_expect.pop_front();
                    if (o_decoded_value !== want.value) begin
                        report_mismatch($sformatf("value %h, want %h",
                                                  o_decoded_value, want.value));
                    end
                    if (o_byte_length !== want.length) begin
                        report_mismatch($sformatf("length %0d, want %0d",
                                                  o_byte_length, want.length));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    end
                end
                w = pick_wait(recv_burst);
                recv_hold <= w;
                i_stall   <= (w != 0);
            end else if (recv_hold != 0) begin
                recv_hold <= recv_hold - 1;
                i_stall   <= (recv_hold > 1);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned directed_bytes;
        int unsigned sel;
        int unsigned len;

        // Directed part: extremes, each format and each way a value can end.
        push_byte(8'h00, MODE_U32, 1'b1);           // zero, ends at region end
        push_byte(8'h7f, MODE_S64, 1'b0);           // -1 in s64
        push_byte(8'h40, MODE_S33, 1'b0);           // -64, sign from bit 6
        push_byte(8'h7f, 3'd7, 1'b0);               // unknown format reads as u32
        push_byte(8'h80, MODE_U64, 1'b1);           // truncated after one byte
        for (int i = 0; i < 4; i++) begin
            push_byte(8'hff, MODE_U32, 1'b0);
        end
        push_byte(8'h1f, MODE_U32, 1'b0);           // u32 overflow on fifth byte
        for (int i = 0; i < 4; i++) begin
            push_byte(8'h80, MODE_S32, 1'b0);
        end
        push_byte(8'hff, MODE_S32, 1'b1);           // too long beats truncation
        for (int i = 0; i < 9; i++) begin
            push_byte(8'hff, MODE_U64, 1'b0);
        end
        push_byte(8'h01, MODE_U64, 1'b0);           // all ones in u64
        directed_bytes = bytes_queued;

        // Random part: mostly well-formed values with random content, mostly
        // short, with broken sequences and raw noise mixed in.
        while (bytes_queued < directed_bytes + RANDOM_BYTES) begin
            sel = $urandom_range(0, 19);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10)
                                              : $urandom_range(1, 3);
            if (sel < 12) begin
                emit_value(pick_mode(), GEN_CLEAN, len);
            end else if (sel < 14) begin
                emit_value(pick_mode(), GEN_TRUNCATED, len);
            end else if (sel < 16) begin
                emit_value(pick_mode(), GEN_OVERLONG, len);
            end else if (sel < 17) begin
                emit_noise($urandom_range(1, 4));
            end else begin
                emit_value(pick_mode(), GEN_CLEAN, MaxBytesLong);
            end
        end

        // Hold reset, then release it once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and every value is back.
        while ((stream_bytes.size() != 0 || i_valid || decoded_expect.size() != 0)
               && idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles < WATCHDOG_LIMIT) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
        end else begin
            if (decoded_expect.size() != 0) begin
                report_mismatch($sformatf("%0d values never arrived",
                                          decoded_expect.size()));
            end
            $display("tb: decoded %0d values from %0d stream bytes", values_seen,
                     bytes_taken);
            $display("tb: ok %0d, overflow %0d, too long %0d, truncated %0d",
                     status_count[ST_OK], status_count[ST_OVERFLOW],
                     status_count[ST_TOO_LONG], status_count[ST_TRUNCATED]);
            if (error_count == 0) begin
                $display("tb: clean");
            end else begin
                $display("tb: errors");
            end
        end
        $finish;
    end

endmodule
